/* sv/csd_pkg.sv */
package csd_pkg;

  // Block sizing
  localparam int MAX_LEN     = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  // Fixed port widths
  localparam int IN_W  = 16;
  localparam int STD_W = 24;
  localparam int CNT_W = 11;

  // Derived datapath widths
  localparam int LEN_LOG   = $clog2(MAX_LEN);
  localparam int CNT_BITS  = $clog2(MAX_LEN + 1);
  localparam int P_W       = 2 * SAMPLE_BITS;
  localparam int MAG_W     = SAMPLE_BITS + FRAC_BITS;
  localparam int MAG_SUM_W = MAG_W + LEN_LOG;
  localparam int SQ_SUM_W  = P_W + LEN_LOG;
  localparam int LHS_W     = CNT_BITS + SQ_SUM_W + 2 * FRAC_BITS;
  localparam int RHS_W     = 2 * MAG_SUM_W;
  localparam int DIFF_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int FIN_STEPS = (DIFF_W + 1) / 2;
  localparam int UNIT_W    = (FIN_STEPS > MAG_W) ? 2 * FIN_STEPS : 2 * MAG_W;
  localparam int STEP_W    = $clog2(UNIT_W + 1);

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic              start;
    unit_op_t          op;
    logic [STEP_W-1:0] steps;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

/* sv/csd_iter_unit.sv */
module csd_iter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  csd_pkg::unit_cmd_t         cmd_i,
  input  logic [csd_pkg::UNIT_W-1:0] x_i,
  input  logic [csd_pkg::UNIT_W-1:0] y_i,
  output csd_pkg::unit_sts_t         sts_o,
  output logic [csd_pkg::UNIT_W-1:0] res_o
);
  import csd_pkg::*;

  logic              busy_r;
  logic              done_r;
  unit_op_t          op_r;
  logic [STEP_W-1:0] cnt_r;
  logic [UNIT_W-1:0] acc_r;
  logic [UNIT_W-1:0] x_r;
  logic [UNIT_W-1:0] y_r;

  logic [UNIT_W-1:0] add_a;
  logic [UNIT_W-1:0] add_b;
  logic              do_sub;
  logic [UNIT_W:0]   add_res;
  logic              fits;

  // One shared adder: accumulate for multiply, trial subtract for root and divide
  always_comb begin
    add_a  = acc_r;
    add_b  = x_r;
    do_sub = 1'b0;
    unique case (op_r)
      OP_MUL: begin
        add_a  = acc_r;
        add_b  = x_r;
        do_sub = 1'b0;
      end
      OP_SQRT: begin
        add_a  = {acc_r[UNIT_W-3:0], x_r[UNIT_W-1:UNIT_W-2]};
        add_b  = {y_r[UNIT_W-3:0], 2'b01};
        do_sub = 1'b1;
      end
      OP_DIV: begin
        add_a  = {acc_r[UNIT_W-2:0], x_r[UNIT_W-1]};
        add_b  = y_r;
        do_sub = 1'b1;
      end
      default: begin
        add_a  = acc_r;
        add_b  = x_r;
        do_sub = 1'b0;
      end
    endcase
    add_res = do_sub ? ({1'b0, add_a} - {1'b0, add_b}) : ({1'b0, add_a} + {1'b0, add_b});
    fits    = ~add_res[UNIT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd_i.start) begin
        busy_r <= 1'b1;
        op_r   <= cmd_i.op;
        cnt_r  <= cmd_i.steps;
        acc_r  <= '0;
        x_r    <= x_i;
        y_r    <= y_i;
      end else if (busy_r) begin
        unique case (op_r)
          OP_MUL: begin
            if (y_r[0]) begin
              acc_r <= add_res[UNIT_W-1:0];
            end
            x_r <= x_r << 1;
            y_r <= y_r >> 1;
          end
          OP_SQRT: begin
            acc_r <= fits ? add_res[UNIT_W-1:0] : add_a;
            y_r   <= {y_r[UNIT_W-2:0], fits};
            x_r   <= x_r << 2;
          end
          OP_DIV: begin
            acc_r <= fits ? add_res[UNIT_W-1:0] : add_a;
            x_r   <= {x_r[UNIT_W-2:0], fits};
          end
          default: begin
          end
        endcase
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (op_r)
      OP_MUL:  res_o = acc_r;
      OP_SQRT: res_o = y_r;
      OP_DIV:  res_o = x_r;
      default: res_o = acc_r;
    endcase
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;

endmodule

/* sv/complex_magnitude_std_dev_unit.sv */
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    in_real_part, in_imag_part, in_last_sample
// out_     out  out_valid/out_ready  out_std_dev, out_sample_count, out_too_long
//
// From acceptance to the earliest next acceptance a sample passes through the square
// multiplier for each part, a start of the shared shift/add/subtract unit, its 24 root
// steps and a collect of the root; no new sample is taken meanwhile.
// A last sample adds work on the same unit: two shift-add multiplies (11 and 34
// steps), a 35-step root and a 35-step divide by the count, each with a start and a
// collect state, then the load of the result register.
// Synchronous active-low reset clears the sums, count and handshake state.
// A finished result waits in the output register; the next packet is accepted
// meanwhile and only a following result stalls on out_ready.
module complex_magnitude_std_dev_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [csd_pkg::IN_W-1:0]  in_real_part,
  input  logic [csd_pkg::IN_W-1:0]  in_imag_part,
  input  logic                      in_last_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [csd_pkg::STD_W-1:0] out_std_dev,
  output logic [csd_pkg::CNT_W-1:0] out_sample_count,
  output logic                      out_too_long
);
  import csd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_RE,
    S_SQ_IM,
    S_MAG_GO,
    S_MAG_WAIT,
    S_LHS_GO,
    S_LHS_WAIT,
    S_RHS_GO,
    S_RHS_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t                 state_r;
  logic [SAMPLE_BITS-1:0] ar_r;
  logic [SAMPLE_BITS-1:0] ai_r;
  logic                   last_r;
  logic [P_W-1:0]         p_r;
  logic [MAG_SUM_W-1:0]   mag_sum_r;
  logic [SQ_SUM_W-1:0]    sq_sum_r;
  logic [CNT_BITS-1:0]    count_r;
  logic                   over_r;
  logic [UNIT_W-1:0]      lhs_r;
  logic                   out_valid_r;
  logic [STD_W-1:0]       out_std_dev_r;
  logic [CNT_W-1:0]       out_sample_count_r;
  logic                   out_too_long_r;

  logic [SAMPLE_BITS-1:0] re_bits;
  logic [SAMPLE_BITS-1:0] im_bits;
  logic [SAMPLE_BITS-1:0] re_abs;
  logic [SAMPLE_BITS-1:0] im_abs;
  logic [SAMPLE_BITS-1:0] mul_op;
  logic [P_W-1:0]         sq_prod;
  logic [FIN_STEPS-1:0]   quot;
  logic [STD_W-1:0]       std_sat;

  unit_cmd_t         ucmd;
  unit_sts_t         usts;
  logic [UNIT_W-1:0] ux;
  logic [UNIT_W-1:0] uy;
  logic [UNIT_W-1:0] ures;

  assign re_bits = in_real_part[SAMPLE_BITS-1:0];
  assign im_bits = in_imag_part[SAMPLE_BITS-1:0];
  assign re_abs  = re_bits[SAMPLE_BITS-1] ? (~re_bits + 1'b1) : re_bits;
  assign im_abs  = im_bits[SAMPLE_BITS-1] ? (~im_bits + 1'b1) : im_bits;

  // Square multiplier, used once for each part
  assign mul_op  = (state_r == S_SQ_RE) ? ar_r : ai_r;
  assign sq_prod = mul_op * mul_op;

  assign quot    = ures[FIN_STEPS-1:0];
  assign std_sat = ((quot >> STD_W) != '0) ? '1 : STD_W'(quot);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ucmd = '0;
    ux   = '0;
    uy   = '0;
    unique case (state_r)
      S_MAG_GO: begin
        ucmd.start = 1'b1;
        ucmd.op    = OP_SQRT;
        ucmd.steps = STEP_W'(MAG_W);
        ux         = UNIT_W'(p_r) << (UNIT_W - P_W);
      end
      S_LHS_GO: begin
        ucmd.start = 1'b1;
        ucmd.op    = OP_MUL;
        ucmd.steps = STEP_W'(CNT_BITS);
        ux         = UNIT_W'(sq_sum_r) << (2 * FRAC_BITS);
        uy         = UNIT_W'(count_r);
      end
      S_RHS_GO: begin
        ucmd.start = 1'b1;
        ucmd.op    = OP_MUL;
        ucmd.steps = STEP_W'(MAG_SUM_W);
        ux         = UNIT_W'(mag_sum_r);
        uy         = UNIT_W'(mag_sum_r);
      end
      S_ROOT_GO: begin
        ucmd.start = 1'b1;
        ucmd.op    = OP_SQRT;
        ucmd.steps = STEP_W'(FIN_STEPS);
        ux         = lhs_r;
      end
      S_DIV_GO: begin
        ucmd.start = 1'b1;
        ucmd.op    = OP_DIV;
        ucmd.steps = STEP_W'(FIN_STEPS);
        ux         = ures << (UNIT_W - FIN_STEPS);
        uy         = UNIT_W'(count_r);
      end
      default: begin
      end
    endcase
  end

  csd_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (ucmd),
    .x_i   (ux),
    .y_i   (uy),
    .sts_o (usts),
    .res_o (ures)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mag_sum_r   <= '0;
      sq_sum_r    <= '0;
      count_r     <= '0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result unless a new one loads in its place
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ar_r   <= re_abs;
            ai_r   <= im_abs;
            last_r <= in_last_sample;
            if (count_r < CNT_BITS'(MAX_LEN)) begin
              state_r <= S_SQ_RE;
            end else begin
              // drop the sample; the packet stays open unless the sample is its last
              over_r  <= 1'b1;
              state_r <= in_last_sample ? S_LHS_GO : S_IDLE;
            end
          end
        end
        S_SQ_RE: begin
          p_r     <= sq_prod;
          state_r <= S_SQ_IM;
        end
        S_SQ_IM: begin
          p_r     <= p_r + sq_prod;
          state_r <= S_MAG_GO;
        end
        S_MAG_GO: begin
          state_r <= S_MAG_WAIT;
        end
        S_MAG_WAIT: begin
          if (usts.done) begin
            mag_sum_r <= mag_sum_r + MAG_SUM_W'(ures[MAG_W-1:0]);
            sq_sum_r  <= sq_sum_r + SQ_SUM_W'(p_r);
            count_r   <= count_r + CNT_BITS'(1);
            state_r   <= last_r ? S_LHS_GO : S_IDLE;
          end
        end
        S_LHS_GO: begin
          state_r <= S_LHS_WAIT;
        end
        S_LHS_WAIT: begin
          if (usts.done) begin
            lhs_r   <= ures;
            state_r <= S_RHS_GO;
          end
        end
        S_RHS_GO: begin
          state_r <= S_RHS_WAIT;
        end
        S_RHS_WAIT: begin
          if (usts.done) begin
            // clamp a negative variance to zero
            lhs_r   <= (lhs_r > ures) ? (lhs_r - ures) : '0;
            state_r <= S_ROOT_GO;
          end
        end
        S_ROOT_GO: begin
          state_r <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (usts.done) begin
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (usts.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_std_dev_r      <= std_sat;
            out_sample_count_r <= CNT_W'(count_r);
            out_too_long_r     <= over_r;
            mag_sum_r          <= '0;
            sq_sum_r           <= '0;
            count_r            <= '0;
            over_r             <= 1'b0;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_std_dev      = out_std_dev_r;
  assign out_sample_count = out_sample_count_r;
  assign out_too_long     = out_too_long_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ucmd.start |-> !usts.busy)
    else $error("shared unit restarted while busy");

  a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!usts.busy && !usts.done))
    else $error("request taken while shared unit active");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(MAX_LEN))
    else $error("sample count beyond packet limit");

  a_too_long_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_too_long) |-> (out_sample_count == CNT_W'(MAX_LEN)))
    else $error("overlong packet reported with short count");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import csd_pkg::*;

  typedef struct packed {
    logic [STD_W-1:0] std_dev;
    logic [CNT_W-1:0] sample_count;
    logic             too_long;
  } packet_stats_t;

  typedef enum int {
    FILL_FULL,
    FILL_SMALL,
    FILL_CONST,
    FILL_EDGE,
    FILL_MID
  } fill_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [IN_W-1:0]  in_real_part;
  logic [IN_W-1:0]  in_imag_part;
  logic             in_last_sample;
  logic             out_valid;
  logic             out_ready;
  logic [STD_W-1:0] out_std_dev;
  logic [CNT_W-1:0] out_sample_count;
  logic             out_too_long;

  // Packet accumulators of the predictor
  logic [63:0] mag_total;
  logic [63:0] sq_total;
  int unsigned taken;
  logic        dropped;

  packet_stats_t pending_stats[$];
  int mismatches = 0;
  int sent = 0;
  int hold_request = 0;
  bit quiet = 0;

  complex_magnitude_std_dev_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_real_part     (in_real_part),
    .in_imag_part     (in_imag_part),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_std_dev      (out_std_dev),
    .out_sample_count (out_sample_count),
    .out_too_long     (out_too_long)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] isqrt_wide(input logic [127:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if ({64'd0, trial} * {64'd0, trial} <= x) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted sample into the packet sums, or mark it dropped past MAX_LEN; close the packet on last.
  task automatic accumulate_sample(input logic [IN_W-1:0] re, input logic [IN_W-1:0] im,
                                   input logic last);
    logic [SAMPLE_BITS-1:0] ar;
    logic [SAMPLE_BITS-1:0] ai;
    logic [63:0]            pw;
    logic [127:0]           lhs;
    logic [127:0]           rhs;
    logic [127:0]           diff;
    logic [63:0]            sd;
    packet_stats_t          st;
    ar = re[SAMPLE_BITS-1] ? ~re[SAMPLE_BITS-1:0] + 1'b1 : re[SAMPLE_BITS-1:0];
    ai = im[SAMPLE_BITS-1] ? ~im[SAMPLE_BITS-1:0] + 1'b1 : im[SAMPLE_BITS-1:0];
    pw = 64'(ar) * 64'(ar) + 64'(ai) * 64'(ai);
    if (taken < MAX_LEN) begin
      mag_total += isqrt_wide(128'(pw) << (2 * FRAC_BITS));
      sq_total  += pw;
      taken++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      sd = '0;
      if (taken != 0) begin
        lhs  = (128'(taken) * 128'(sq_total)) << (2 * FRAC_BITS);
        rhs  = 128'(mag_total) * 128'(mag_total);
        // clamp a negative variance to zero
        diff = (lhs > rhs) ? lhs - rhs : '0;
        sd   = isqrt_wide(diff) / taken;
      end
      if (sd > 64'hFF_FFFF) sd = 64'hFF_FFFF;
      st.std_dev      = sd[STD_W-1:0];
      st.sample_count = taken[CNT_W-1:0];
      st.too_long     = dropped;
      pending_stats.push_back(st);
      mag_total = '0;
      sq_total  = '0;
      taken     = 0;
      dropped   = 1'b0;
    end
  endtask

  function automatic int next_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic int next_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [IN_W-1:0] random_value(input fill_t fill);
    case (fill)
      FILL_SMALL: return IN_W'($urandom_range(0, 16)) - IN_W'(8);
      FILL_MID:   return IN_W'($urandom_range(0, 4000)) - IN_W'(2000);
      FILL_EDGE: begin
        case ($urandom_range(0, 6))
          0:       return 16'h8000;
          1:       return 16'h8001;
          2:       return 16'hFFFF;
          3:       return 16'h0000;
          4:       return 16'h0001;
          5:       return 16'h7FFE;
          default: return 16'h7FFF;
        endcase
      end
      default:    return IN_W'($urandom);
    endcase
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_sample(input logic [IN_W-1:0] re, input logic [IN_W-1:0] im,
                             input logic last);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_real_part   <= re;
    in_imag_part   <= im;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_sample(re, im, last);
    sent++;
  endtask

  task automatic test_extremes();
    send_sample(16'h0000, 16'h0000, 1'b1);
    send_sample(16'h8000, 16'h8000, 1'b1);
    send_sample(16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(16'h8000, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h8000, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b1);
    // identical samples give zero variance
    send_sample(16'd1000, -16'sd1000, 1'b0);
    send_sample(16'd1000, -16'sd1000, 1'b0);
    send_sample(16'd1000, -16'sd1000, 1'b1);
    send_sample(16'h0001, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h0001, 1'b0);
    send_sample(16'h0001, 16'h0001, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(16'h7FFF, 16'h8000, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_long_packets();
    quiet = 1'b1;
    for (int i = 0; i < MAX_LEN; i++)
      send_sample(random_value(FILL_FULL), random_value(FILL_FULL), i == MAX_LEN - 1);
    quiet = 1'b0;
    // samples past the limit, the last one too, must not count
    for (int i = 0; i < MAX_LEN + 3; i++) begin
      if (i < MAX_LEN)
        send_sample(random_value(FILL_MID), random_value(FILL_MID), 1'b0);
      else
        send_sample(16'h8000, 16'h7FFF, i == MAX_LEN + 2);
    end
    send_sample(16'h0003, 16'h0004, 1'b0);
    send_sample(16'h0006, 16'h0008, 1'b1);
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_request = 600;
    for (int p = 0; p < 8; p++) begin
      send_sample(random_value(FILL_FULL), random_value(FILL_FULL), 1'b0);
      send_sample(random_value(FILL_FULL), random_value(FILL_FULL), 1'b1);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int              first;
    int              len;
    int              r;
    fill_t           fill;
    logic [IN_W-1:0] cre;
    logic [IN_W-1:0] cim;
    first = sent;
    while (sent - first < 700) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else             len = $urandom_range(41, 150);
      fill = fill_t'($urandom_range(0, 4));
      cre  = random_value(FILL_FULL);
      cim  = random_value(FILL_FULL);
      for (int i = 0; i < len; i++) begin
        if (fill == FILL_CONST)
          send_sample(cre, cim, i == len - 1);
        else
          send_sample(random_value(fill), random_value(fill), i == len - 1);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    mag_total = '0;
    sq_total  = '0;
    taken     = 0;
    dropped   = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_real_part   <= '0;
    in_imag_part   <= '0;
    in_last_sample <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_long_packets();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : result_checker
    int            stall;
    packet_stats_t want;
    stall = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_stats.size() == 0) begin
          $error("unexpected result: std_dev %0d sample_count %0d too_long %0d",
                 out_std_dev, out_sample_count, out_too_long);
          mismatches++;
        end else begin
          want = pending_stats.pop_front();
          if (out_std_dev !== want.std_dev) begin
            $error("std_dev: expected %0d, got %0d", want.std_dev, out_std_dev);
            mismatches++;
          end
          if (out_sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want.sample_count,
                   out_sample_count);
            mismatches++;
          end
          if (out_too_long !== want.too_long) begin
            $error("too_long: expected %0d, got %0d", want.too_long, out_too_long);
            mismatches++;
          end
        end
      end
      // a long hold-off takes priority over the random stalls
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && !quiet) begin
        stall = next_stall();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
